[hw/rtl/apci_lc_pkg.sv]
// Shared types, codes and constants of the APCI link controller.
// No dependencies; imported by every module of the block.
package apci_lc_pkg;

  localparam int SEQ_W       = 15;
  localparam int TIMER_W     = 32;
  localparam int CFG_DATA_W  = 22;
  localparam int CFG_INDEX_W = 3;
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  // operations
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_OPEN  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // transmit kinds
  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_S    = 2'd1;
  localparam logic [1:0] TX_U    = 2'd2;
  localparam logic [1:0] TX_GI   = 2'd3;

  // link status
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SEQ_ERROR    = 3'd1;
  localparam logic [2:0] ST_STOP_CON     = 3'd2;
  localparam logic [2:0] ST_KEEPALIVE_TO = 3'd3;
  localparam logic [2:0] ST_STARTDT_TO   = 3'd4;

  // U-frame control octets
  localparam logic [7:0] U_STARTDT_ACT = 8'h07;
  localparam logic [7:0] U_STARTDT_CON = 8'h0b;
  localparam logic [7:0] U_STOPDT_ACT  = 8'h13;
  localparam logic [7:0] U_STOPDT_CON  = 8'h23;
  localparam logic [7:0] U_TESTFR_ACT  = 8'h43;
  localparam logic [7:0] U_TESTFR_CON  = 8'h83;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_LIMIT       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEPALIVE_IVAL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STARTDT_TIMEOUT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GI_IVAL         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDR    = 3'd5;

  typedef struct packed {
    logic [7:0]  ack_limit;
    logic [15:0] ack_timeout;
    logic [21:0] keepalive_interval;
    logic [21:0] startdt_timeout;
    logic [21:0] gi_interval;
    logic [15:0] station_address;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ack_limit:          8'd8,
    ack_timeout:        16'd10000,
    keepalive_interval: 22'd20000,
    startdt_timeout:    22'd10000,
    gi_interval:        22'd0,
    station_address:    16'd1
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] octet0;
    logic [7:0] octet1;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       u_code;
    logic [SEQ_W-1:0] send_number;
    logic [SEQ_W-1:0] recv_number;
    logic [15:0]      gi_address;
    logic [2:0]       link_status;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_IDX_W-1:0]      last_idx;
  } group_t;

endpackage

[hw/rtl/apci_lc_core.sv]
// Session state and per-item protocol logic of the APCI link controller.
// Depends on apci_lc_pkg; produces one packed result group per item that gives results.
module apci_lc_core import apci_lc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  item_t  item,
  input  cfg_t   cfg,
  output logic   push,
  output group_t push_group
);

  logic [SEQ_W-1:0]   tx_sequence, tx_sequence_next;
  logic [SEQ_W-1:0]   rx_sequence, rx_sequence_next;
  logic [7:0]         unacked_count, unacked_count_next, unacked_inc;
  logic               started_flag, started_flag_next;
  logic               keepalive_pending, keepalive_pending_next;
  logic               initial_gi_done, initial_gi_done_next;
  logic               session_open, session_open_next;
  logic [TIMER_W-1:0] ms_since_tx, ms_since_tx_next;
  logic [TIMER_W-1:0] ms_since_gi, ms_since_gi_next;
  logic [TIMER_W-1:0] ms_since_keepalive, ms_since_keepalive_next;
  logic [TIMER_W-1:0] ms_since_ack_check, ms_since_ack_check_next;

  logic [TIMER_W-1:0] tt_tx, tt_gi, tt_ka, tt_ack;
  logic               gi_fire, ka_fire, ka_fail;
  result_t [MAX_RESULTS-1:0] slot;
  logic [MAX_RESULTS-1:0]    slot_valid;
  logic [RES_IDX_W:0]        n;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == '1) ? v : v + TIMER_W'(1);
  endfunction

  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] code,
                                 input logic [SEQ_W-1:0] sn, input logic [SEQ_W-1:0] rn,
                                 input logic [15:0] ga, input logic [2:0] st);
    result_t r;
    r.kind        = kind;
    r.u_code      = code;
    r.send_number = sn;
    r.recv_number = rn;
    r.gi_address  = ga;
    r.link_status = st;
    mk = r;
  endfunction

  always_comb begin
    tx_sequence_next        = tx_sequence;
    rx_sequence_next        = rx_sequence;
    unacked_count_next      = unacked_count;
    started_flag_next       = started_flag;
    keepalive_pending_next  = keepalive_pending;
    initial_gi_done_next    = initial_gi_done;
    session_open_next       = session_open;
    ms_since_tx_next        = ms_since_tx;
    ms_since_gi_next        = ms_since_gi;
    ms_since_keepalive_next = ms_since_keepalive;
    ms_since_ack_check_next = ms_since_ack_check;
    slot       = '0;
    slot_valid = '0;
    unacked_inc = (unacked_count == 8'hff) ? unacked_count : unacked_count + 8'd1;
    tt_tx   = sat_inc(ms_since_tx);
    tt_gi   = sat_inc(ms_since_gi);
    tt_ka   = sat_inc(ms_since_keepalive);
    tt_ack  = sat_inc(ms_since_ack_check);
    gi_fire = 1'b0;
    ka_fire = 1'b0;
    ka_fail = 1'b0;

    if (item_valid) begin
      unique case (item.operation)
        OP_FRAME: begin
          if (session_open) begin
            if (!item.octet0[0]) begin
              if ({item.octet1, item.octet0[7:1]} != rx_sequence) begin
                slot_valid[0]     = 1'b1;
                slot[0]           = mk(TX_NONE, '0, '0, '0, '0, ST_SEQ_ERROR);
                session_open_next = 1'b0;
              end else begin
                rx_sequence_next = rx_sequence + SEQ_W'(1);
                if (unacked_inc >= cfg.ack_limit) begin
                  slot_valid[0]      = 1'b1;
                  slot[0]            = mk(TX_S, '0, '0, rx_sequence_next, '0, ST_OK);
                  unacked_count_next = '0;
                  ms_since_tx_next   = '0;
                end else begin
                  unacked_count_next = unacked_inc;
                end
              end
            end else if (item.octet0[1]) begin
              case (item.octet0)
                U_STARTDT_CON: started_flag_next = 1'b1;
                U_STOPDT_CON: begin
                  slot_valid[0]     = 1'b1;
                  slot[0]           = mk(TX_NONE, '0, '0, '0, '0, ST_STOP_CON);
                  session_open_next = 1'b0;
                end
                U_TESTFR_ACT: begin
                  slot_valid[0]    = 1'b1;
                  slot[0]          = mk(TX_U, U_TESTFR_CON, '0, '0, '0, ST_OK);
                  ms_since_tx_next = '0;
                end
                U_TESTFR_CON: keepalive_pending_next = 1'b0;
                default: ;
              endcase
            end
          end
        end
        OP_TICK: begin
          if (session_open) begin
            // general interrogation: initial one, else periodic
            if (started_flag && !initial_gi_done) begin
              gi_fire              = 1'b1;
              initial_gi_done_next = 1'b1;
            end else if (started_flag && cfg.gi_interval != '0 &&
                         tt_gi >= TIMER_W'(cfg.gi_interval)) begin
              gi_fire = 1'b1;
            end
            if (gi_fire) begin
              slot_valid[0]    = 1'b1;
              slot[0]          = mk(TX_GI, '0, tx_sequence, rx_sequence,
                                    cfg.station_address, ST_OK);
              tx_sequence_next = tx_sequence + SEQ_W'(1);
              tt_tx            = '0;
              tt_gi            = '0;
            end
            // acknowledge timeout
            if (unacked_count != '0 && tt_ack >= TIMER_W'(cfg.ack_timeout)) begin
              slot_valid[1]      = 1'b1;
              slot[1]            = mk(TX_S, '0, '0, rx_sequence, '0, ST_OK);
              unacked_count_next = '0;
              tt_tx              = '0;
              tt_ack             = '0;
            end else if (unacked_count == '0) begin
              tt_ack = '0;
            end
            // keepalive
            ka_fire = tt_ka >= TIMER_W'(cfg.keepalive_interval);
            if (ka_fire) begin
              if (keepalive_pending) begin
                ka_fail           = 1'b1;
                slot_valid[2]     = 1'b1;
                slot[2]           = mk(TX_NONE, '0, '0, '0, '0, ST_KEEPALIVE_TO);
                session_open_next = 1'b0;
              end else begin
                slot_valid[2]          = 1'b1;
                slot[2]                = mk(TX_U, U_TESTFR_ACT, '0, '0, '0, ST_OK);
                keepalive_pending_next = 1'b1;
                tt_ka                  = '0;
                tt_tx                  = '0;
              end
            end
            // STARTDT timeout
            if (!ka_fail && !started_flag && tt_tx >= TIMER_W'(cfg.startdt_timeout)) begin
              slot_valid[3]     = 1'b1;
              slot[3]           = mk(TX_NONE, '0, '0, '0, '0, ST_STARTDT_TO);
              session_open_next = 1'b0;
            end
            ms_since_tx_next        = tt_tx;
            ms_since_gi_next        = tt_gi;
            ms_since_keepalive_next = tt_ka;
            ms_since_ack_check_next = tt_ack;
          end
        end
        OP_OPEN: begin
          tx_sequence_next        = '0;
          rx_sequence_next        = '0;
          unacked_count_next      = '0;
          started_flag_next       = 1'b0;
          keepalive_pending_next  = 1'b0;
          initial_gi_done_next    = 1'b0;
          session_open_next       = 1'b1;
          ms_since_tx_next        = '0;
          ms_since_gi_next        = '0;
          ms_since_keepalive_next = '0;
          ms_since_ack_check_next = '0;
          slot_valid[0]           = 1'b1;
          slot[0]                 = mk(TX_U, U_STARTDT_ACT, '0, '0, '0, ST_OK);
        end
        default: begin
          if (session_open) begin
            slot_valid[0]     = 1'b1;
            slot[0]           = mk(TX_U, U_STOPDT_ACT, '0, '0, '0, ST_OK);
            ms_since_tx_next  = '0;
            session_open_next = 1'b0;
          end
        end
      endcase
    end
  end

  // pack the valid slots in order
  always_comb begin
    push_group = '0;
    n          = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (slot_valid[i]) begin
        push_group.res[n[RES_IDX_W-1:0]] = slot[i];
        n = n + (RES_IDX_W+1)'(1);
      end
    end
    push_group.last_idx = n[RES_IDX_W-1:0] - RES_IDX_W'(1);
  end

  assign push = |slot_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_sequence        <= '0;
      rx_sequence        <= '0;
      unacked_count      <= '0;
      started_flag       <= 1'b0;
      keepalive_pending  <= 1'b0;
      initial_gi_done    <= 1'b0;
      session_open       <= 1'b0;
      ms_since_tx        <= '0;
      ms_since_gi        <= '0;
      ms_since_keepalive <= '0;
      ms_since_ack_check <= '0;
    end else begin
      tx_sequence        <= tx_sequence_next;
      rx_sequence        <= rx_sequence_next;
      unacked_count      <= unacked_count_next;
      started_flag       <= started_flag_next;
      keepalive_pending  <= keepalive_pending_next;
      initial_gi_done    <= initial_gi_done_next;
      session_open       <= session_open_next;
      ms_since_tx        <= ms_since_tx_next;
      ms_since_gi        <= ms_since_gi_next;
      ms_since_keepalive <= ms_since_keepalive_next;
      ms_since_ack_check <= ms_since_ack_check_next;
    end
  end

endmodule

[hw/rtl/apci_lc_rsq.sv]
// Result queue: holds result groups and hands them out one result per transfer.
// Depends on apci_lc_pkg for group_t and result_t.
module apci_lc_rsq import apci_lc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  group_t                       push_group,
  input  logic                         pop,
  output logic                         valid,
  output result_t                      result,
  output logic                         last,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  group_t               entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [RES_IDX_W-1:0] sub;
  logic                 group_done;

  assign valid      = count != '0;
  assign result     = entries[rd_ptr].res[sub];
  assign last       = sub == entries[rd_ptr].last_idx;
  assign group_done = pop && last;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      sub    <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (group_done) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
        sub    <= '0;
      end else if (pop) begin
        sub <= sub + RES_IDX_W'(1);
      end
      case ({push, group_done})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/iec104_apci_link_controller.sv]
// Top level of the APCI link controller: input register, config registers,
// session core and result queue. Depends on apci_lc_pkg, apci_lc_core, apci_lc_rsq.
//
// Usage:
//   Item channel (item_valid/item_stall): operation plus the four control
//   octets of a received frame; operation selects frame, 1 ms tick, open or stop.
//   Result channel (result_valid/result_stall): one transmit request or link
//   status per transfer; last marks the final result of an item.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects the register,
//   cfg_data carries the value; indexes above 5 are ignored.
// Timing:
//   An item is registered on acceptance and processed on the next edge, which
//   writes its results into the queue. An item accepts in every cycle while
//   each item gives at most one result and result_stall stays low; an item with k
//   results holds the result channel for k transfers. The queue holds DEPTH
//   item result groups; item_stall rises once the queue and the input register
//   could not take another group.
// Reset: closes the session, clears all timers and counters, empties the
//   queue and restores register defaults. While result_stall is high, results
//   wait in the queue and items keep flowing until it fills.
module iec104_apci_link_controller import apci_lc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             operation,
  input  logic [7:0]             ctrl_octet0,
  input  logic [7:0]             ctrl_octet1,
  input  logic [7:0]             ctrl_octet2,
  input  logic [7:0]             ctrl_octet3,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             tx_kind,
  output logic [7:0]             u_code,
  output logic [SEQ_W-1:0]       send_number,
  output logic [SEQ_W-1:0]       recv_number,
  output logic [15:0]            gi_address,
  output logic [2:0]             link_status,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(DEPTH+1);

  cfg_t             cfg;
  item_t            s1_item;
  logic             s1_valid;
  logic             push;
  group_t           push_group;
  result_t          result;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   occupancy;

  // octets 2 and 3 carry N(R), which the master does not track
  assign occupancy  = {1'b0, count} + (CNT_W+1)'(s1_valid);
  assign item_stall = rst || (occupancy >= (CNT_W+1)'(DEPTH));
  assign cfg_ready  = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_valid && !item_stall;
    end
  end

  always_ff @(posedge clk) begin
    s1_item.operation <= operation;
    s1_item.octet0    <= ctrl_octet0;
    s1_item.octet1    <= ctrl_octet1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACK_LIMIT:       cfg.ack_limit          <= cfg_data[7:0];
        REG_ACK_TIMEOUT:     cfg.ack_timeout        <= cfg_data[15:0];
        REG_KEEPALIVE_IVAL:  cfg.keepalive_interval <= cfg_data;
        REG_STARTDT_TIMEOUT: cfg.startdt_timeout    <= cfg_data;
        REG_GI_IVAL:         cfg.gi_interval        <= cfg_data;
        REG_STATION_ADDR:    cfg.station_address    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  apci_lc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item       (s1_item),
    .cfg        (cfg),
    .push       (push),
    .push_group (push_group)
  );

  apci_lc_rsq #(
    .DEPTH (DEPTH)
  ) u_rsq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (result_valid && !result_stall),
    .valid      (result_valid),
    .result     (result),
    .last       (last),
    .count      (count)
  );

  assign tx_kind     = result.kind;
  assign u_code      = result.u_code;
  assign send_number = result.send_number;
  assign recv_number = result.recv_number;
  assign gi_address  = result.gi_address;
  assign link_status = result.link_status;

endmodule

[hw/rtl/apci_lc_checker.sv]
// Port-level checks for the APCI link controller, bound to the top level.
// Depends on apci_lc_pkg and iec104_apci_link_controller.
module apci_lc_checker import apci_lc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic [1:0] tx_kind,
  input logic [7:0] u_code,
  input logic [2:0] link_status,
  input logic       last
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  a_tx_status_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && tx_kind != TX_NONE) |-> link_status == ST_OK)
    else $error("transmit request carries a link status");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && tx_kind == TX_NONE) |-> (link_status != ST_OK && last))
    else $error("status result is empty or not final");

  a_ucode_only_u: assert property (@(posedge clk) disable iff (rst)
    (result_valid && tx_kind != TX_U) |-> u_code == '0)
    else $error("U code on a non-U result");

endmodule

bind iec104_apci_link_controller apci_lc_checker u_checker (.*);

[tb/tb_iec104_apci_link_controller.sv]
`timescale 1ns / 1ps
// Self-checking bench for the APCI link controller: directed table and
// randomized sessions over several register settings.
// Depends on apci_lc_pkg and iec104_apci_link_controller.
module tb_iec104_apci_link_controller import apci_lc_pkg::*; ();

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 5000;
  localparam logic [1:0] S_FMT = 2'b01;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic [1:0]             operation;
  logic [7:0]             ctrl_octet0;
  logic [7:0]             ctrl_octet1;
  logic [7:0]             ctrl_octet2;
  logic [7:0]             ctrl_octet3;
  logic                   result_valid;
  logic                   result_stall;
  logic [1:0]             tx_kind;
  logic [7:0]             u_code;
  logic [SEQ_W-1:0]       send_number;
  logic [SEQ_W-1:0]       recv_number;
  logic [15:0]            gi_address;
  logic [2:0]             link_status;
  logic                   last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  iec104_apci_link_controller dut (.*);

  typedef struct packed {
    result_t res;
    logic    lst;
  } apci_out_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] o0;
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    logic       typed;
    logic [1:0] kind;
    logic [7:0] ucode;
    logic [2:0] status;
  } stim_row_t;

  stim_row_t dir_rows [26] = '{
    '{OP_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_STOP,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_OPEN,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TX_U, U_STARTDT_ACT, ST_OK},
    '{OP_FRAME, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, 8'h02, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, 8'h01, 8'hFF, 8'hFF, 8'hFF, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, U_TESTFR_ACT, 8'h00, 8'h00, 8'h00, 1'b1, TX_U, U_TESTFR_CON, ST_OK},
    '{OP_FRAME, U_STARTDT_CON, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, U_TESTFR_CON, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_FRAME, 8'hFE, 8'hFF, 8'h00, 8'h00, 1'b1, TX_NONE, 8'h00, ST_SEQ_ERROR},
    '{OP_OPEN,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, TX_U, U_STARTDT_ACT, ST_OK},
    '{OP_OPEN,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TX_U, U_STARTDT_ACT, ST_OK},
    '{OP_FRAME, U_STOPDT_CON, 8'h00, 8'h00, 8'h00, 1'b1, TX_NONE, 8'h00, ST_STOP_CON},
    '{OP_OPEN,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TX_U, U_STARTDT_ACT, ST_OK},
    '{OP_STOP,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, TX_U, U_STOPDT_ACT, ST_OK},
    '{OP_OPEN,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TX_U, U_STARTDT_ACT, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK},
    '{OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, TX_NONE, 8'h00, ST_OK}
  };

  // session model state
  cfg_t             lk_cfg = CFG_RESET;
  logic [SEQ_W-1:0] lk_tx_seq = '0;
  logic [SEQ_W-1:0] lk_rx_seq = '0;
  logic [7:0]       lk_unacked = '0;
  logic             lk_started = 1'b0;
  logic             lk_ka_pending = 1'b0;
  logic             lk_gi_done = 1'b0;
  logic             lk_open = 1'b0;
  logic [31:0]      ms_tx = '0;
  logic [31:0]      ms_gi = '0;
  logic [31:0]      ms_ka = '0;
  logic [31:0]      ms_ack = '0;

  result_t   step_res [$];
  apci_out_t apci_out_q [$];
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        hold_req = 1'b0;
  bit        no_idle = 1'b0;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] uc,
                                     input logic [SEQ_W-1:0] sn, input logic [SEQ_W-1:0] rn,
                                     input logic [15:0] ga, input logic [2:0] st);
    result_t r;
    if (step_res.size() >= MAX_RESULTS) return;
    r.kind        = kind;
    r.u_code      = uc;
    r.send_number = sn;
    r.recv_number = rn;
    r.gi_address  = ga;
    r.link_status = st;
    step_res.push_back(r);
  endfunction

  function automatic void send_s();
    add_result(TX_S, 8'h00, '0, lk_rx_seq, 16'h0000, ST_OK);
    lk_unacked = '0;
    ms_tx = '0;
  endfunction

  function automatic void send_u(input logic [7:0] code);
    add_result(TX_U, code, '0, '0, 16'h0000, ST_OK);
    ms_tx = '0;
  endfunction

  function automatic void send_gi();
    add_result(TX_GI, 8'h00, lk_tx_seq, lk_rx_seq, lk_cfg.station_address, ST_OK);
    lk_tx_seq = lk_tx_seq + SEQ_W'(1);
    ms_tx = '0;
    ms_gi = '0;
  endfunction

  function automatic void link_fail(input logic [2:0] st);
    add_result(TX_NONE, 8'h00, '0, '0, 16'h0000, st);
    lk_open = 1'b0;
  endfunction

  function automatic void apci_step(input logic [1:0] op, input logic [7:0] o0,
                                    input logic [7:0] o1);
    logic [SEQ_W-1:0] ns;
    step_res.delete();
    case (op)
      OP_FRAME: if (lk_open) begin
        if (!o0[0]) begin
          ns = {o1, o0[7:1]};
          if (ns != lk_rx_seq) begin
            link_fail(ST_SEQ_ERROR);
          end else begin
            lk_rx_seq = lk_rx_seq + SEQ_W'(1);
            if (lk_unacked != 8'hFF) lk_unacked = lk_unacked + 8'd1;
            if (lk_unacked >= lk_cfg.ack_limit) send_s();
          end
        end else if (o0[1:0] != S_FMT) begin
          case (o0)
            U_STARTDT_CON: lk_started = 1'b1;
            U_STOPDT_CON:  link_fail(ST_STOP_CON);
            U_TESTFR_ACT:  send_u(U_TESTFR_CON);
            U_TESTFR_CON:  lk_ka_pending = 1'b0;
            default: ;
          endcase
        end
      end
      OP_TICK: if (lk_open) begin
        ms_tx  = sat_inc(ms_tx);
        ms_gi  = sat_inc(ms_gi);
        ms_ka  = sat_inc(ms_ka);
        ms_ack = sat_inc(ms_ack);
        if (lk_started && !lk_gi_done) begin
          send_gi();
          lk_gi_done = 1'b1;
        end
        if (lk_started && lk_cfg.gi_interval != '0 && ms_gi >= lk_cfg.gi_interval) send_gi();
        if (lk_unacked != '0 && ms_ack >= lk_cfg.ack_timeout) begin
          send_s();
          ms_ack = '0;
        end else if (lk_unacked == '0) begin
          ms_ack = '0;
        end
        if (ms_ka >= lk_cfg.keepalive_interval) begin
          if (lk_ka_pending) begin
            link_fail(ST_KEEPALIVE_TO);
            return;
          end
          send_u(U_TESTFR_ACT);
          lk_ka_pending = 1'b1;
          ms_ka = '0;
        end
        if (!lk_started && ms_tx >= lk_cfg.startdt_timeout) link_fail(ST_STARTDT_TO);
      end
      OP_OPEN: begin
        lk_tx_seq = '0;
        lk_rx_seq = '0;
        lk_unacked = '0;
        lk_started = 1'b0;
        lk_ka_pending = 1'b0;
        lk_gi_done = 1'b0;
        ms_tx = '0;
        ms_gi = '0;
        ms_ka = '0;
        ms_ack = '0;
        lk_open = 1'b1;
        send_u(U_STARTDT_ACT);
      end
      OP_STOP: if (lk_open) begin
        send_u(U_STOPDT_ACT);
        lk_open = 1'b0;
      end
    endcase
  endfunction

  function automatic void chk(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall, plus a long hold-off on request
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_idle && ($urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk) begin : result_check
    apci_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (apci_out_q.size() == 0) begin
        $error("unexpected result: tx_kind %0d link_status %0d", tx_kind, link_status);
        errors++;
      end else begin
        want = apci_out_q.pop_front();
        chk("tx_kind", want.res.kind, tx_kind);
        chk("u_code", want.res.u_code, u_code);
        chk("send_number", want.res.send_number, send_number);
        chk("recv_number", want.res.recv_number, recv_number);
        chk("gi_address", want.res.gi_address, gi_address);
        chk("link_status", want.res.link_status, link_status);
        chk("last", want.lst, last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[iec104_apci_link_controller] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [21:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACK_LIMIT:       lk_cfg.ack_limit = data[7:0];
      REG_ACK_TIMEOUT:     lk_cfg.ack_timeout = data[15:0];
      REG_KEEPALIVE_IVAL:  lk_cfg.keepalive_interval = data;
      REG_STARTDT_TIMEOUT: lk_cfg.startdt_timeout = data;
      REG_GI_IVAL:         lk_cfg.gi_interval = data;
      REG_STATION_ADDR:    lk_cfg.station_address = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // narrow registers get random junk above their width
  task automatic apply_cfg(input logic [7:0] win, input logic [15:0] ackto,
                           input logic [21:0] ka, input logic [21:0] sd,
                           input logic [21:0] gi, input logic [21:0] stn);
    reg_write(REG_ACK_LIMIT, (22'($urandom) & 22'h3FFF00) | {14'd0, win});
    reg_write(REG_ACK_TIMEOUT, (22'($urandom) & 22'h3F0000) | {6'd0, ackto});
    reg_write(REG_KEEPALIVE_IVAL, ka);
    reg_write(REG_STARTDT_TIMEOUT, sd);
    reg_write(REG_GI_IVAL, gi);
    reg_write(REG_STATION_ADDR, stn);
  endtask

  task automatic send_apci(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    operation   <= op;
    ctrl_octet0 <= a;
    ctrl_octet1 <= b;
    ctrl_octet2 <= c;
    ctrl_octet3 <= d;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic apply_apci(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d, input logic typed,
                            input logic [1:0] kind, input logic [7:0] ucode,
                            input logic [2:0] status);
    apci_out_t o;
    send_apci(op, a, b, c, d);
    apci_step(op, a, b);
    if (typed) begin
      o = '0;
      o.res.kind = kind;
      o.res.u_code = ucode;
      o.res.link_status = status;
      o.lst = 1'b1;
      apci_out_q.push_back(o);
    end else begin
      foreach (step_res[k]) begin
        o.res = step_res[k];
        o.lst = (k == step_res.size() - 1);
        apci_out_q.push_back(o);
      end
    end
  endtask

  task automatic wait_link_quiet();
    @(negedge clk);
    item_valid <= 1'b0;
    while (apci_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed session traffic, steered by the model state
  task automatic draw_apci(output logic [1:0] op, output logic [7:0] a, output logic [7:0] b);
    int r;
    logic [SEQ_W-1:0] ns;
    r = $urandom_range(99);
    a = 8'($urandom);
    b = 8'($urandom);
    op = OP_FRAME;
    if (!lk_open) begin
      op = (r < 85) ? OP_OPEN : 2'($urandom_range(3));
    end else if (r < 30) begin
      op = OP_TICK;
    end else if (r < 60) begin
      a = {lk_rx_seq[6:0], 1'b0};
      b = lk_rx_seq[14:7];
    end else if (r < 70) begin
      a = lk_started ? U_TESTFR_ACT : U_STARTDT_CON;
    end else if (r < 76) begin
      a = U_TESTFR_CON;
    end else if (r < 79) begin
      a = U_STARTDT_CON;
    end else if (r < 82) begin
      ns = lk_rx_seq ^ 15'($urandom_range(32767, 1));
      a = {ns[6:0], 1'b0};
      b = ns[14:7];
    end else if (r < 84) begin
      op = OP_STOP;
    end else if (r < 85) begin
      a = U_STOPDT_CON;
    end else if (r < 87) begin
      op = OP_OPEN;
    end else if (r < 91) begin
      a[1:0] = S_FMT;
    end
  endtask

  task automatic run_session(input int quota);
    int done;
    logic [1:0] op;
    logic [7:0] a;
    logic [7:0] b;
    done = 0;
    while (done < quota) begin
      draw_apci(op, a, b);
      if (lk_open || op == OP_OPEN) done++;
      apply_apci(op, a, b, 8'($urandom), 8'($urandom), 1'b0, TX_NONE, 8'h00, ST_OK);
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    item_valid = 1'b0;
    operation = OP_FRAME;
    ctrl_octet0 = '0;
    ctrl_octet1 = '0;
    ctrl_octet2 = '0;
    ctrl_octet3 = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACK_LIMIT;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_cfg(8'd2, 16'd3, 22'd3, 22'd5, 22'd0, 22'h00A5C3);
    foreach (dir_rows[i])
      apply_apci(dir_rows[i].op, dir_rows[i].o0, dir_rows[i].o1, dir_rows[i].o2,
                 dir_rows[i].o3, dir_rows[i].typed, dir_rows[i].kind,
                 dir_rows[i].ucode, dir_rows[i].status);
    wait_link_quiet();

    apply_cfg(8'd1, 16'd1, 22'd4, 22'd2, 22'd3, 22'd0);
    run_session(60);
    wait_link_quiet();

    apply_cfg(8'd255, 16'd65535, 22'd3600000, 22'd3600000, 22'd3600000, 22'h00FFFF);
    run_session(60);
    wait_link_quiet();

    // zero thresholds fire on the first tick
    apply_cfg(8'd0, 16'd0, 22'd1, 22'd0, 22'd1, 22'($urandom));
    run_session(60);
    wait_link_quiet();

    apply_cfg(8'($urandom_range(6, 1)), 16'($urandom_range(8, 1)),
              22'($urandom_range(12, 2)), 22'($urandom_range(10, 1)),
              22'($urandom_range(6, 0)), 22'($urandom));
    hold_req = 1'b1;
    run_session(60);
    wait_link_quiet();

    reg_write(REG_UNUSED_LO, 22'($urandom));
    reg_write(REG_UNUSED_HI, 22'($urandom));
    apply_cfg(8'($urandom_range(6, 1)), 16'($urandom_range(8, 1)),
              22'($urandom_range(12, 2)), 22'($urandom_range(10, 1)),
              22'($urandom_range(6, 0)), 22'($urandom));
    run_session(30);
    wait_link_quiet();
    run_session(30);
    wait_link_quiet();

    no_idle = 1'b1;
    apply_cfg(8'($urandom_range(6, 1)), 16'($urandom_range(8, 1)),
              22'($urandom_range(12, 2)), 22'($urandom_range(10, 1)),
              22'($urandom_range(6, 0)), 22'($urandom));
    run_session(60);
    wait_link_quiet();

    if (errors == 0)
      $display("[iec104_apci_link_controller] OK");
    else
      $display("[iec104_apci_link_controller] ERROR");
    $finish;
  end

endmodule
